// File: hdl/dkn_pkg.sv
// Shared types and constants for the double-byte keyword normalizer.
// Holds the lead/trail range ROM, the row kinds and the result-set types.
// No dependencies.
package dkn_pkg;

	typedef enum logic [2:0] {
		KIND_COPY  = 3'd0,
		KIND_DIGIT = 3'd1,
		KIND_UPPER = 3'd2,
		KIND_LOWER = 3'd3,
		KIND_EXT   = 3'd4,
		KIND_PICT  = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] lead_lo;
		logic [7:0] trail_lo;
		logic [7:0] lead_hi;
		logic [7:0] trail_hi;
		kind_t      kind;
	} row_t;

	localparam int unsigned ROW_COUNT = 26;

	localparam row_t ROWS [ROW_COUNT] = '{
		'{8'hB0, 8'hA1, 8'hC8, 8'hFE, KIND_COPY },
		'{8'hCA, 8'hA1, 8'hFD, 8'hFE, KIND_COPY },
		'{8'hAA, 8'hA1, 8'hAA, 8'hF3, KIND_COPY },
		'{8'hAB, 8'hA1, 8'hAB, 8'hF6, KIND_COPY },
		'{8'hA5, 8'hC1, 8'hA5, 8'hD8, KIND_COPY },
		'{8'hA5, 8'hE1, 8'hA5, 8'hF8, KIND_COPY },
		'{8'hA8, 8'hA1, 8'hA8, 8'hA4, KIND_COPY },
		'{8'hA8, 8'hA6, 8'hA8, 8'hA6, KIND_COPY },
		'{8'hA8, 8'hA8, 8'hA8, 8'hAF, KIND_COPY },
		'{8'hA9, 8'hA1, 8'hA9, 8'hAF, KIND_COPY },
		'{8'hAC, 8'hA1, 8'hAC, 8'hC1, KIND_COPY },
		'{8'hAC, 8'hD1, 8'hAC, 8'hF1, KIND_COPY },
		'{8'hA4, 8'hA1, 8'hA4, 8'hD3, KIND_COPY },
		'{8'hA4, 8'hD5, 8'hA4, 8'hFE, KIND_COPY },
		'{8'hA3, 8'hB0, 8'hA3, 8'hB9, KIND_DIGIT},
		'{8'hA3, 8'hC1, 8'hA3, 8'hDA, KIND_UPPER},
		'{8'hA3, 8'hE1, 8'hA3, 8'hFA, KIND_LOWER},
		'{8'hA1, 8'hA1, 8'hA1, 8'hFE, KIND_PICT },
		'{8'hA2, 8'hA1, 8'hA2, 8'hE5, KIND_PICT },
		'{8'hA3, 8'hA1, 8'hA3, 8'hFE, KIND_PICT },
		'{8'hA5, 8'hA1, 8'hA5, 8'hAA, KIND_PICT },
		'{8'hA5, 8'hB0, 8'hA5, 8'hB9, KIND_PICT },
		'{8'hA7, 8'hA1, 8'hA7, 8'hFE, KIND_PICT },
		'{8'hA8, 8'hB1, 8'hA8, 8'hFE, KIND_PICT },
		'{8'hA9, 8'hB0, 8'hA9, 8'hFE, KIND_PICT },
		'{8'h81, 8'h20, 8'hC5, 8'hFF, KIND_EXT  }
	};

	localparam logic [7:0] DIGIT_LO     = 8'h30;
	localparam logic [7:0] DIGIT_HI     = 8'h39;
	localparam logic [7:0] UPPER_LO     = 8'h41;
	localparam logic [7:0] UPPER_HI     = 8'h5A;
	localparam logic [7:0] LOWER_LO     = 8'h61;
	localparam logic [7:0] LOWER_HI     = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;
	localparam logic [7:0] FW_UP_OFFSET = 8'h80;
	localparam logic [7:0] FW_LO_OFFSET = 8'hA0;
	localparam logic [7:0] ASCII_MAX    = 8'h7F;
	localparam logic [7:0] EXT_SPLIT    = 8'hA0;
	localparam logic [7:0] EXT_TRAIL_LO = 8'h81;
	localparam logic [7:0] EXT_TRAIL_HI = 8'hFE;

	localparam int unsigned RES_MAX = 3;
	localparam int unsigned CNT_W   = $clog2(RES_MAX + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]     cnt;
		res_t [RES_MAX-1:0]   res;
	} res_set_t;

endpackage

// File: hdl/dkn_ifs.sv
// Valid/ready channel interfaces for the keyword normalizer.
// One interface for the raw byte stream, one for the keyword stream.
// No dependencies.
interface dkn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface dkn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_end;

	modport source (output valid, output out_byte, output is_end, input ready);
	modport sink (input valid, input out_byte, input is_end, output ready);
endinterface

// File: hdl/dkn_classify.sv
// Combinational byte classifier: ASCII filter, lead/trail range ROM lookup
// and end-marker append. Depends on dkn_pkg.
module dkn_classify (
	input  logic              lead_pending,
	input  logic [7:0]        held_lead,
	input  logic [7:0]        cur_byte,
	input  logic              eot,
	input  logic              drop_pict,
	output dkn_pkg::res_set_t res_set,
	output logic              lead_next,
	output logic              lead_load
);

	logic [dkn_pkg::ROW_COUNT-1:0] hit;
	logic                          found;
	dkn_pkg::kind_t                kind;
	logic                          trail_letter;
	logic                          ext_keep;
	logic [1:0]                    pair_n;
	logic [7:0]                    pb0;
	logic [7:0]                    pb1;
	logic [dkn_pkg::CNT_W-1:0]     base_n;

	always_comb begin
		for (int j = 0; j < dkn_pkg::ROW_COUNT; j++) begin
			hit[j] = !(dkn_pkg::ROWS[j].kind == dkn_pkg::KIND_PICT && drop_pict)
				&& held_lead >= dkn_pkg::ROWS[j].lead_lo
				&& held_lead <= dkn_pkg::ROWS[j].lead_hi
				&& cur_byte >= dkn_pkg::ROWS[j].trail_lo
				&& cur_byte <= dkn_pkg::ROWS[j].trail_hi;
		end
	end

	// first matching row wins
	always_comb begin
		found = 1'b0;
		kind  = dkn_pkg::KIND_COPY;
		for (int j = 0; j < dkn_pkg::ROW_COUNT; j++) begin
			if (hit[j] && !found) begin
				found = 1'b1;
				kind  = dkn_pkg::ROWS[j].kind;
			end
		end
	end

	always_comb begin
		trail_letter = (cur_byte >= dkn_pkg::UPPER_LO && cur_byte <= dkn_pkg::UPPER_HI)
			|| (cur_byte >= dkn_pkg::LOWER_LO && cur_byte <= dkn_pkg::LOWER_HI);
		priority if (cur_byte <= dkn_pkg::ASCII_MAX) begin
			ext_keep = trail_letter;
		end else if (held_lead <= dkn_pkg::EXT_SPLIT) begin
			ext_keep = cur_byte >= dkn_pkg::EXT_TRAIL_LO && cur_byte <= dkn_pkg::EXT_TRAIL_HI;
		end else begin
			ext_keep = cur_byte >= dkn_pkg::EXT_TRAIL_LO && cur_byte <= dkn_pkg::EXT_SPLIT;
		end
	end

	always_comb begin
		pair_n = 2'd0;
		pb0    = held_lead;
		pb1    = cur_byte;
		if (found) begin
			unique case (kind)
				dkn_pkg::KIND_DIGIT, dkn_pkg::KIND_UPPER: begin
					pair_n = 2'd1;
					pb0    = cur_byte - dkn_pkg::FW_UP_OFFSET;
				end
				dkn_pkg::KIND_LOWER: begin
					pair_n = 2'd1;
					pb0    = cur_byte - dkn_pkg::FW_LO_OFFSET;
				end
				dkn_pkg::KIND_EXT: begin
					pair_n = ext_keep ? 2'd2 : 2'd0;
				end
				default: begin
					pair_n = 2'd2;
				end
			endcase
		end
	end

	always_comb begin
		res_set   = '0;
		base_n    = '0;
		lead_next = 1'b0;
		lead_load = 1'b0;
		priority if (lead_pending) begin
			base_n            = dkn_pkg::CNT_W'(pair_n);
			res_set.res[0]    = '{data: pb0, last: 1'b0};
			res_set.res[1]    = '{data: pb1, last: 1'b0};
		end else if (cur_byte[7]) begin
			// hold the lead until its trail arrives; drop it at end of text
			lead_next = !eot;
			lead_load = !eot;
		end else if ((cur_byte >= dkn_pkg::DIGIT_LO && cur_byte <= dkn_pkg::DIGIT_HI)
			|| (cur_byte >= dkn_pkg::UPPER_LO && cur_byte <= dkn_pkg::UPPER_HI)) begin
			base_n         = dkn_pkg::CNT_W'(1);
			res_set.res[0] = '{data: cur_byte, last: 1'b0};
		end else if (cur_byte >= dkn_pkg::LOWER_LO && cur_byte <= dkn_pkg::LOWER_HI) begin
			base_n         = dkn_pkg::CNT_W'(1);
			res_set.res[0] = '{data: cur_byte - dkn_pkg::CASE_OFFSET, last: 1'b0};
		end else begin
			base_n = '0;
		end

		res_set.cnt = base_n;
		if (eot) begin
			res_set.cnt = base_n + dkn_pkg::CNT_W'(1);
			unique case (base_n)
				dkn_pkg::CNT_W'(0): res_set.res[0] = '{data: 8'h00, last: 1'b1};
				dkn_pkg::CNT_W'(1): res_set.res[1] = '{data: 8'h00, last: 1'b1};
				default:            res_set.res[2] = '{data: 8'h00, last: 1'b1};
			endcase
		end
	end

endmodule

// File: hdl/dkn_result_buf.sv
// Result register: holds up to three keyword beats of one item and shifts them
// out one beat per cycle while ready. Depends on dkn_pkg and dkn_out_if.
module dkn_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dkn_pkg::res_set_t res_set,
	output logic              free,
	dkn_out_if.source         out_ch
);

	dkn_pkg::res_t [dkn_pkg::RES_MAX-1:0] res_s2;
	logic [dkn_pkg::CNT_W-1:0]            cnt_s2;
	logic                                 pop;

	assign out_ch.valid    = cnt_s2 != '0;
	assign out_ch.out_byte = res_s2[0].data;
	assign out_ch.is_end   = res_s2[0].last;
	assign pop             = out_ch.valid && out_ch.ready;
	assign free            = (cnt_s2 == '0) || (cnt_s2 == dkn_pkg::CNT_W'(1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= res_set.cnt;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - dkn_pkg::CNT_W'(1);
		end
	end

	// advance the queue toward the head on each beat
	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_set.res;
		end else if (pop) begin
			for (int i = 0; i < dkn_pkg::RES_MAX - 1; i++) begin
				res_s2[i] <= res_s2[i+1];
			end
		end
	end

endmodule

// File: hdl/dbcs_keyword_normalizer.sv
// The normalizer takes one raw text byte per cycle unless in_ch.ready is low and
// gives keyword bytes on its output, the end marker last. A byte with no result
// only passes the input register; one with results (at most three: lead, trail,
// end marker) loads the result register, which drains one beat a cycle while
// the receiver is ready. The input stalls only on a byte with results while the
// result register is busy. drop_pict_q resets to 1; the user writes it through
// cfg_we/cfg_wdata only while the block is idle, which the block does not enforce.
// Depends on dkn_pkg, dkn_ifs, dkn_classify and dkn_result_buf.
module dbcs_keyword_normalizer (
	input  logic      clk,
	input  logic      arst_n,
	dkn_in_if.sink    in_ch,
	dkn_out_if.source out_ch,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	logic              valid_s1;
	logic [7:0]        in_byte_s1;
	logic              eot_s1;
	logic              lead_pending_q;
	logic [7:0]        held_lead_q;
	logic              drop_pict_q;
	dkn_pkg::res_set_t res_set;
	logic              lead_next;
	logic              lead_load;
	logic              buf_free;
	logic              has_res;
	logic              adv_s1;
	logic              take;

	assign has_res     = res_set.cnt != '0;
	assign adv_s1      = valid_s1 && (!has_res || buf_free);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_pict_q <= 1'b1;
		end else if (cfg_we) begin
			drop_pict_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			in_byte_s1 <= in_ch.in_byte;
			eot_s1     <= in_ch.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			held_lead_q    <= 8'h00;
		end else if (adv_s1) begin
			lead_pending_q <= lead_next;
			if (lead_load) begin
				held_lead_q <= in_byte_s1;
			end
		end
	end

	dkn_classify u_classify (
		.lead_pending (lead_pending_q),
		.held_lead    (held_lead_q),
		.cur_byte     (in_byte_s1),
		.eot          (eot_s1),
		.drop_pict    (drop_pict_q),
		.res_set      (res_set),
		.lead_next    (lead_next),
		.lead_load    (lead_load)
	);

	dkn_result_buf u_result_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv_s1 && has_res),
		.res_set (res_set),
		.free    (buf_free),
		.out_ch  (out_ch)
	);

endmodule

// File: dv/dkn_keyword_checker.sv
// Checker for the keyword normalizer: watches both channels and the config port,
// predicts every keyword beat and compares the beats that come out against it.
// Depends on dkn_pkg (row kinds) and dkn_ifs.
module dkn_keyword_checker (
	input  logic clk,
	input  logic arst_n,
	dkn_in_if    in_mon,
	dkn_out_if   out_mon,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		logic [7:0]     lead_lo;
		logic [7:0]     lead_hi;
		logic [7:0]     trail_lo;
		logic [7:0]     trail_hi;
		dkn_pkg::kind_t kind;
	} code_range_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_end;
	} kw_beat_t;

	localparam int NUM_RANGES = 26;

	// Searched in order; the first hit decides the outcome.
	localparam code_range_t CODE_RANGES [NUM_RANGES] = '{
		'{8'hB0, 8'hC8, 8'hA1, 8'hFE, dkn_pkg::KIND_COPY },
		'{8'hCA, 8'hFD, 8'hA1, 8'hFE, dkn_pkg::KIND_COPY },
		'{8'hAA, 8'hAA, 8'hA1, 8'hF3, dkn_pkg::KIND_COPY },
		'{8'hAB, 8'hAB, 8'hA1, 8'hF6, dkn_pkg::KIND_COPY },
		'{8'hA5, 8'hA5, 8'hC1, 8'hD8, dkn_pkg::KIND_COPY },
		'{8'hA5, 8'hA5, 8'hE1, 8'hF8, dkn_pkg::KIND_COPY },
		'{8'hA8, 8'hA8, 8'hA1, 8'hA4, dkn_pkg::KIND_COPY },
		'{8'hA8, 8'hA8, 8'hA6, 8'hA6, dkn_pkg::KIND_COPY },
		'{8'hA8, 8'hA8, 8'hA8, 8'hAF, dkn_pkg::KIND_COPY },
		'{8'hA9, 8'hA9, 8'hA1, 8'hAF, dkn_pkg::KIND_COPY },
		'{8'hAC, 8'hAC, 8'hA1, 8'hC1, dkn_pkg::KIND_COPY },
		'{8'hAC, 8'hAC, 8'hD1, 8'hF1, dkn_pkg::KIND_COPY },
		'{8'hA4, 8'hA4, 8'hA1, 8'hD3, dkn_pkg::KIND_COPY },
		'{8'hA4, 8'hA4, 8'hD5, 8'hFE, dkn_pkg::KIND_COPY },
		'{8'hA3, 8'hA3, 8'hB0, 8'hB9, dkn_pkg::KIND_DIGIT},
		'{8'hA3, 8'hA3, 8'hC1, 8'hDA, dkn_pkg::KIND_UPPER},
		'{8'hA3, 8'hA3, 8'hE1, 8'hFA, dkn_pkg::KIND_LOWER},
		'{8'hA1, 8'hA1, 8'hA1, 8'hFE, dkn_pkg::KIND_PICT },
		'{8'hA2, 8'hA2, 8'hA1, 8'hE5, dkn_pkg::KIND_PICT },
		'{8'hA3, 8'hA3, 8'hA1, 8'hFE, dkn_pkg::KIND_PICT },
		'{8'hA5, 8'hA5, 8'hA1, 8'hAA, dkn_pkg::KIND_PICT },
		'{8'hA5, 8'hA5, 8'hB0, 8'hB9, dkn_pkg::KIND_PICT },
		'{8'hA7, 8'hA7, 8'hA1, 8'hFE, dkn_pkg::KIND_PICT },
		'{8'hA8, 8'hA8, 8'hB1, 8'hFE, dkn_pkg::KIND_PICT },
		'{8'hA9, 8'hA9, 8'hB0, 8'hFE, dkn_pkg::KIND_PICT },
		'{8'h81, 8'hC5, 8'h20, 8'hFF, dkn_pkg::KIND_EXT  }
	};

	kw_beat_t   keyword_q [$];
	logic       drop_pict;
	logic       lead_held;
	logic [7:0] held_lead;

	task automatic queue_keyword_byte(input logic [7:0] b, input logic last);
		keyword_q.push_back('{out_byte: b, is_end: last});
	endtask

	task automatic predict_pair(input logic [7:0] lead, input logic [7:0] trail);
		bit hit;
		bit keep;
		hit = 1'b0;
		for (int r = 0; r < NUM_RANGES; r++) begin
			if (!hit && !(CODE_RANGES[r].kind == dkn_pkg::KIND_PICT && drop_pict)
			    && lead >= CODE_RANGES[r].lead_lo && lead <= CODE_RANGES[r].lead_hi
			    && trail >= CODE_RANGES[r].trail_lo
			    && trail <= CODE_RANGES[r].trail_hi) begin
				hit = 1'b1;
				case (CODE_RANGES[r].kind)
					dkn_pkg::KIND_DIGIT, dkn_pkg::KIND_UPPER: begin
						queue_keyword_byte(trail - 8'h80, 1'b0);
					end
					dkn_pkg::KIND_LOWER: begin
						queue_keyword_byte(trail - 8'hA0, 1'b0);
					end
					dkn_pkg::KIND_EXT: begin
						// keep only pairs that are legal in the extended Hangul area
						if (trail <= 8'h7F)
							keep = (trail >= "A" && trail <= "Z")
								|| (trail >= "a" && trail <= "z");
						else if (lead <= 8'hA0)
							keep = trail >= 8'h81 && trail <= 8'hFE;
						else
							keep = trail >= 8'h81 && trail <= 8'hA0;
						if (keep) begin
							queue_keyword_byte(lead, 1'b0);
							queue_keyword_byte(trail, 1'b0);
						end
					end
					default: begin
						queue_keyword_byte(lead, 1'b0);
						queue_keyword_byte(trail, 1'b0);
					end
				endcase
			end
		end
	endtask

	task automatic predict_text_byte(input logic [7:0] b, input logic last);
		if (lead_held) begin
			lead_held = 1'b0;
			predict_pair(held_lead, b);
		end else if (b[7]) begin
			held_lead = b;
			lead_held = 1'b1;
		end else if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z")) begin
			queue_keyword_byte(b, 1'b0);
		end else if (b >= "a" && b <= "z") begin
			queue_keyword_byte(b - 8'd32, 1'b0);
		end
		// end of text closes the keyword and drops any unpaired lead
		if (last) begin
			lead_held = 1'b0;
			queue_keyword_byte(8'h00, 1'b1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		kw_beat_t want;
		if (!arst_n) begin
			keyword_q.delete();
			drop_pict = 1'b1;
			lead_held = 1'b0;
			held_lead = 8'h00;
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				drop_pict = cfg_wdata;
			if (out_mon.valid && out_mon.ready) begin
				if (keyword_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected keyword beat: expected none, got byte %02h end %0b",
						$time, out_mon.out_byte, out_mon.is_end);
				end else begin
					want = keyword_q.pop_front();
					if (out_mon.out_byte !== want.out_byte || out_mon.is_end !== want.is_end) begin
						mismatches++;
						$display("%0t: keyword beat mismatch: expected byte %02h end %0b,",
							$time, want.out_byte, want.is_end,
							" got byte %02h end %0b", out_mon.out_byte, out_mon.is_end);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				predict_text_byte(in_mon.in_byte, in_mon.end_of_text);
			pending = keyword_q.size();
		end
	end

endmodule

// File: dv/dbcs_keyword_normalizer_tb.sv
// Top of the keyword normalizer testbench: clock, reset, text stimulus,
// config writes, output back-pressure and the verdict.
// Depends on dkn_pkg, dkn_ifs, dbcs_keyword_normalizer and dkn_keyword_checker.
module dbcs_keyword_normalizer_tb;

	localparam int DIRECTED_LEN = 25;
	localparam int PHASE_ITEMS  = 105;
	localparam int STALL_CYCLES = 80;

	// {end_of_text, byte}
	localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
		{1'b0, 8'h30}, {1'b0, 8'h39}, {1'b0, 8'h41}, {1'b0, 8'h61}, {1'b0, 8'h7A},
		{1'b1, 8'h7F},
		{1'b0, 8'hA3}, {1'b0, 8'hB0}, {1'b0, 8'hA3}, {1'b0, 8'hDA},
		{1'b0, 8'hA3}, {1'b0, 8'hFA}, {1'b0, 8'hB0}, {1'b0, 8'hA1},
		{1'b0, 8'h81}, {1'b0, 8'h41}, {1'b0, 8'h81}, {1'b0, 8'h20},
		{1'b0, 8'hA1}, {1'b0, 8'hA1}, {1'b0, 8'h01},
		{1'b1, 8'hC9},
		{1'b0, 8'hFD}, {1'b1, 8'hFE}, {1'b0, 8'h5A}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	bit          stall_req;
	int          items_sent;
	int          mismatches;
	int          pending;

	dkn_in_if  in_ch ();
	dkn_out_if out_ch ();

	dbcs_keyword_normalizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	dkn_keyword_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.in_byte     <= b;
		in_ch.end_of_text <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// One ASCII byte, one random byte or one lead/trail pair (sometimes only the lead), sometimes closing the keyword.
	task automatic send_token();
		int unsigned sel;
		logic [7:0]  lead;
		logic [7:0]  trail;
		logic        stop;
		sel  = $urandom_range(99);
		stop = ($urandom_range(11) == 0);
		if (sel < 25) begin
			send_beat(8'($urandom_range(1, 127)), stop);
		end else if (sel < 35) begin
			send_beat(8'($urandom_range(1, 255)), stop);
		end else begin
			if ($urandom_range(1))
				lead = 8'($urandom_range(8'hA1, 8'hAC));
			else
				lead = 8'($urandom_range(8'h80, 8'hFF));
			case ($urandom_range(3))
				0, 1: trail = 8'($urandom_range(8'hA1, 8'hFE));
				2: trail = 8'($urandom_range(8'h20, 8'h7F));
				default: trail = 8'($urandom_range(1, 255));
			endcase
			if (stop && $urandom_range(3) == 0) begin
				send_beat(lead, 1'b1);
			end else begin
				send_beat(lead, 1'b0);
				send_beat(trail, stop);
			end
		end
	endtask

	// Hold the sender until every predicted beat is out, then let the pipe empty.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_drop_pict(input logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
		input bit with_stall);
		int start;
		bit stalled;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = items_sent;
		stalled = 1'b0;
		while (items_sent - start < PHASE_ITEMS) begin
			// request the long hold-off once, partway into the phase
			if (with_stall && !stalled && items_sent - start >= 30) begin
				stall_req = 1'b1;
				stalled = 1'b1;
			end
			send_token();
		end
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ch.ready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_req = 1'b0;
			end
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		in_ch.valid       = 1'b0;
		in_ch.in_byte     = 8'h00;
		in_ch.end_of_text = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 1'b0;
		tx_idle_pct       = 38;
		rx_idle_pct       = 61;
		stall_req         = 1'b0;
		items_sent        = 0;
		arst_n            = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pictographs dropped out of reset
		foreach (DIRECTED[i])
			send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
		settle();
		write_drop_pict(1'b0);
		send_beat(8'hA1, 1'b0);
		send_beat(8'hA1, 1'b0);
		run_phase(38, 61, 1'b0);
		settle();
		write_drop_pict(1'b1);
		run_phase(61, 38, 1'b1);
		settle();
		write_drop_pict(1'b0);
		run_phase(0, 0, 1'b0);
		settle();

		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

endmodule
